// ----- hdl/utz_pkg.sv -----
`default_nettype none

package utz_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ZONE_HOURS = 2'd0;
    localparam logic [1:0] CFG_ZONE_EAST  = 2'd1;

    localparam logic [3:0] ZONE_HOURS_RESET = 4'd8;
    localparam logic       ZONE_EAST_RESET  = 1'b1;
    localparam logic [3:0] ZONE_HOURS_MAX   = 4'd12;

    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
    localparam logic [3:0] MONTH_JAN        = 4'd1;
    localparam logic [3:0] MONTH_FEB        = 4'd2;
    localparam logic [3:0] MONTH_DEC        = 4'd12;
    localparam logic [4:0] DAYS_LONG        = 5'd31;
    localparam logic [4:0] DAYS_SHORT       = 5'd30;
    localparam logic [4:0] DAYS_FEB_COMMON  = 5'd28;
    localparam logic [4:0] DAYS_FEB_LEAP    = 5'd29;

    // Year field values (since 1900) of the non-leap century years 1900 and 2100
    localparam logic [7:0] YEAR_1900 = 8'd0;
    localparam logic [7:0] YEAR_2100 = 8'd200;

    // Stage 1: hour shifted, day direction decided, leap flag known
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       shifted;
        logic       fwd;
        logic       back;
        logic       leap;
    } utz_s1_t;

    // Stage 2: month lengths looked up
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [3:0] prev_month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       shifted;
        logic       fwd;
        logic       back;
        logic       month_ok;
        logic [4:0] len_cur;
        logic [4:0] len_prev;
    } utz_s2_t;

    // Final result
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       shifted;
    } utz_res_t;

    // Gregorian leap test on the year field (real year is 1900 + field).
    // 1900 is a multiple of 4, so the low bits of the field decide; the
    // only century years in range are 1900, 2000 and 2100.
    function automatic logic is_leap(input logic [7:0] yfield);
        logic by4;
        by4 = (yfield[1:0] == 2'b00);
        return by4 && (yfield != YEAR_1900) && (yfield != YEAR_2100);
    endfunction

    // Days in month m (1..12)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB_COMMON;
            4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/utz_date_roll.sv -----
`default_nettype none

// Day/month/year rollover for one day forward or back
module utz_date_roll (
    input  var utz_pkg::utz_s2_t  s2,
    output var utz_pkg::utz_res_t res
);

    always_comb begin
        res.year    = s2.year;
        res.month   = s2.month;
        res.day     = s2.day;
        res.hour    = s2.hour;
        res.minute  = s2.minute;
        res.second  = s2.second;
        res.shifted = s2.shifted;

        if (s2.month_ok && s2.fwd) begin
            // forward one day
            if (s2.day < s2.len_cur) begin
                res.day = s2.day + 5'd1;
            end else begin
                res.day = 5'd1;
                if (s2.month == utz_pkg::MONTH_DEC) begin
                    res.month = utz_pkg::MONTH_JAN;
                    res.year  = s2.year + 8'd1;
                end else begin
                    res.month = s2.month + 4'd1;
                end
            end
        end else if (s2.month_ok && s2.back) begin
            // back one day
            if (s2.day > 5'd1) begin
                res.day = s2.day - 5'd1;
            end else if (s2.month == utz_pkg::MONTH_JAN) begin
                res.month = utz_pkg::MONTH_DEC;
                res.day   = utz_pkg::DAYS_LONG;
                res.year  = s2.year - 8'd1;
            end else begin
                res.month = s2.prev_month;
                res.day   = s2.len_prev;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/utc_time_zone_shift_unit.sv -----
`default_nettype none

// UTC to local time shift. Each timestamp accepted on the s_ channel gives
// one result on the m_ channel, in order, registered after each step
// (hour shift, month length lookup, date rollover into the output register).
// A new transaction is accepted every cycle as long as the output side keeps
// taking results; each pipeline stage holds its item while the stage after it
// is full and stalled. The offset (zone_hours, index 0) and direction
// (zone_east, index 1) are written through the cfg_ port, which is always
// ready; write them only while the pipeline is empty. An offset of 0 or above
// 12 passes the timestamp through with m_shifted low. Minute and second are
// carried through unchanged; the year field wraps modulo 256.
module utc_time_zone_shift_unit (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] cfg_index,
    input  wire  [3:0] cfg_data,

    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_year,
    input  wire  [3:0] s_month,
    input  wire  [4:0] s_day,
    input  wire  [4:0] s_hour,
    input  wire  [5:0] s_minute,
    input  wire  [5:0] s_second,

    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_year,
    output logic [3:0] m_out_month,
    output logic [4:0] m_out_day,
    output logic [4:0] m_out_hour,
    output logic [5:0] m_out_minute,
    output logic [5:0] m_out_second,
    output logic       m_shifted
);

    logic [3:0] zone_hours_reg;
    logic       zone_east_reg;

    logic                v1_reg, v2_reg, v3_reg;
    utz_pkg::utz_s1_t    s1_reg, s1_next;
    utz_pkg::utz_s2_t    s2_reg, s2_next;
    utz_pkg::utz_res_t   s3_reg, s3_next;

    logic adv1, adv2, adv3;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_hours_reg <= utz_pkg::ZONE_HOURS_RESET;
            zone_east_reg  <= utz_pkg::ZONE_EAST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                utz_pkg::CFG_ZONE_HOURS: zone_hours_reg <= cfg_data;
                utz_pkg::CFG_ZONE_EAST:  zone_east_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    // Stage 1: hour shift and day direction
    always_comb begin
        logic       zone_ok;
        logic [5:0] hsum;
        logic [5:0] hwest;
        zone_ok = (zone_hours_reg != 4'd0) && (zone_hours_reg <= utz_pkg::ZONE_HOURS_MAX);
        hsum    = {1'b0, s_hour} + {2'b00, zone_hours_reg};
        hwest   = {1'b0, s_hour} + utz_pkg::HOURS_PER_DAY - {2'b00, zone_hours_reg};

        s1_next.year    = s_year;
        s1_next.month   = s_month;
        s1_next.day     = s_day;
        s1_next.minute  = s_minute;
        s1_next.second  = s_second;
        s1_next.leap    = utz_pkg::is_leap(s_year);
        s1_next.shifted = zone_ok;
        s1_next.hour    = s_hour;
        s1_next.fwd     = 1'b0;
        s1_next.back    = 1'b0;

        if (zone_ok) begin
            if (zone_east_reg) begin
                if (hsum < utz_pkg::HOURS_PER_DAY) begin
                    s1_next.hour = hsum[4:0];
                end else begin
                    s1_next.hour = 5'(hsum - utz_pkg::HOURS_PER_DAY);
                    s1_next.fwd  = 1'b1;
                end
            end else begin
                if ({1'b0, s_hour} >= {2'b00, zone_hours_reg}) begin
                    s1_next.hour = s_hour - {1'b0, zone_hours_reg};
                end else begin
                    s1_next.hour = hwest[4:0];
                    s1_next.back = 1'b1;
                end
            end
        end
    end

    // Stage 2: month lengths of this and the previous month
    always_comb begin
        s2_next.year       = s1_reg.year;
        s2_next.month      = s1_reg.month;
        s2_next.prev_month = s1_reg.month - 4'd1;
        s2_next.day        = s1_reg.day;
        s2_next.hour       = s1_reg.hour;
        s2_next.minute     = s1_reg.minute;
        s2_next.second     = s1_reg.second;
        s2_next.shifted    = s1_reg.shifted;
        s2_next.fwd        = s1_reg.fwd;
        s2_next.back       = s1_reg.back;
        s2_next.month_ok   = (s1_reg.month >= utz_pkg::MONTH_JAN) &&
                             (s1_reg.month <= utz_pkg::MONTH_DEC);
        s2_next.len_cur    = utz_pkg::month_len(s1_reg.month, s1_reg.leap);
        s2_next.len_prev   = utz_pkg::month_len(s1_reg.month - 4'd1, s1_reg.leap);
    end

    // Stage 3: date rollover
    utz_date_roll u_roll (
        .s2  (s2_reg),
        .res (s3_next)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
    end

    assign m_valid      = v3_reg;
    assign m_out_year   = s3_reg.year;
    assign m_out_month  = s3_reg.month;
    assign m_out_day    = s3_reg.day;
    assign m_out_hour   = s3_reg.hour;
    assign m_out_minute = s3_reg.minute;
    assign m_out_second = s3_reg.second;
    assign m_shifted    = s3_reg.shifted;

    // A stalled middle stage keeps its item
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv2 |=> v2_reg && $stable(s2_reg))
        else $error("stage 2 item changed while stalled");

    // Day cannot move both ways
    a_dir_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> !(s1_reg.fwd && s1_reg.back))
        else $error("forward and back both set");

    // No date move without a shift
    a_no_move_unshifted: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !s2_reg.shifted |-> !s2_reg.fwd && !s2_reg.back)
        else $error("date move on unshifted item");

    // Pipeline empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !$past(aresetn) |-> !v1_reg && !v2_reg && !v3_reg)
        else $error("valid bit set after reset");

endmodule

`default_nettype wire

// ----- verif/utc_time_zone_shift_unit_tb.sv -----
module utc_time_zone_shift_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 8;

    // Indexes outside the register map; writes there must change nothing
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } utc_stamp_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_year;
    logic [3:0] s_month;
    logic [4:0] s_day;
    logic [4:0] s_hour;
    logic [5:0] s_minute;
    logic [5:0] s_second;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_year;
    logic [3:0] m_out_month;
    logic [4:0] m_out_day;
    logic [4:0] m_out_hour;
    logic [5:0] m_out_minute;
    logic [5:0] m_out_second;
    logic       m_shifted;

    // Predictor copy of the zone registers
    logic [3:0] zone_hours_q;
    logic       zone_east_q;

    utz_pkg::utz_res_t local_times_due[$];
    utz_pkg::utz_res_t due_stamp;
    int       mismatch_count;
    int       cycle_count;
    bit       idle_on;
    int       sink_hold_request;
    int       sink_stall_left;

    utc_time_zone_shift_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_year      (s_year),
        .s_month     (s_month),
        .s_day       (s_day),
        .s_hour      (s_hour),
        .s_minute    (s_minute),
        .s_second    (s_second),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_year  (m_out_year),
        .m_out_month (m_out_month),
        .m_out_day   (m_out_day),
        .m_out_hour  (m_out_hour),
        .m_out_minute(m_out_minute),
        .m_out_second(m_out_second),
        .m_shifted   (m_shifted)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Gregorian month length; yfield counts years from 1900
    function automatic int unsigned days_in_month(input int unsigned mo,
                                                  input int unsigned yfield);
        int unsigned y;
        bit          leap;
        y    = 1900 + yfield;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (mo)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Expected local time for one UTC stamp under the given zone setting
    function automatic utz_pkg::utz_res_t shift_to_local(input utc_stamp_t ts,
                                                         input logic [3:0] zh,
                                                         input logic east);
        utz_pkg::utz_res_t r;
        int unsigned yy, mo, dd, hh, g;
        bit          month_valid;
        yy = 32'(ts.year);
        mo = 32'(ts.month);
        dd = 32'(ts.day);
        hh = 32'(ts.hour);
        g  = 32'(zh);
        month_valid = (mo >= 1) && (mo <= 12);
        r.shifted = 1'b0;
        if (g != 0 && g <= 12) begin
            r.shifted = 1'b1;
            if (east) begin
                if (hh + g < 24) begin
                    hh = hh + g;
                end else begin
                    hh = hh + g - 24;
                    if (month_valid) begin
                        if (dd < days_in_month(mo, yy)) begin
                            dd++;
                        end else begin
                            dd = 1;
                            if (mo == 12) begin
                                mo = 1;
                                yy = (yy + 1) % 256;
                            end else begin
                                mo++;
                            end
                        end
                    end
                end
            end else begin
                if (hh >= g) begin
                    hh = hh - g;
                end else begin
                    hh = hh + 24 - g;
                    if (month_valid) begin
                        if (dd > 1) begin
                            dd--;
                        end else if (mo == 1) begin
                            mo = 12;
                            dd = 31;
                            yy = (yy + 255) % 256;
                        end else begin
                            mo--;
                            dd = days_in_month(mo, yy);
                        end
                    end
                end
            end
        end
        r.year   = yy[7:0];
        r.month  = mo[3:0];
        r.day    = dd[4:0];
        r.hour   = hh[4:0];
        r.minute = ts.minute;
        r.second = ts.second;
        return r;
    endfunction

    function automatic utc_stamp_t make_stamp(input int y, input int mo, input int d,
                                              input int h, input int mi, input int s);
        utc_stamp_t ts;
        ts.year   = y[7:0];
        ts.month  = mo[3:0];
        ts.day    = d[4:0];
        ts.hour   = h[4:0];
        ts.minute = mi[5:0];
        ts.second = s[5:0];
        return ts;
    endfunction

    // Mostly valid dates biased to month starts and ends and to hours near midnight,
    // with some raw noise over the full field widths
    function automatic utc_stamp_t random_stamp();
        utc_stamp_t  ts;
        int unsigned len;
        if ($urandom_range(0, 6) == 0) begin
            ts = utc_stamp_t'($urandom);
            ts.year = 8'($urandom);
        end else begin
            ts.year  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2) * 100)
                                                   : 8'($urandom);
            ts.month = 4'($urandom_range(1, 12));
            len = days_in_month(32'(ts.month), 32'(ts.year));
            case ($urandom_range(0, 4))
                0:       ts.day = 5'd1;
                1:       ts.day = 5'(len);
                2:       ts.day = 5'(len - 1);
                default: ts.day = 5'($urandom_range(1, len));
            endcase
            case ($urandom_range(0, 3))
                0:       ts.hour = 5'($urandom_range(0, 3));
                1:       ts.hour = 5'($urandom_range(20, 23));
                default: ts.hour = 5'($urandom_range(0, 23));
            endcase
            ts.minute = 6'($urandom_range(0, 59));
            ts.second = 6'($urandom_range(0, 60));
        end
        return ts;
    endfunction

    // One timestamp transaction; s_valid is left high for a following item
    task automatic send_stamp(input utc_stamp_t ts);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_year   <= ts.year;
        s_month  <= ts.month;
        s_day    <= ts.day;
        s_hour   <= ts.hour;
        s_minute <= ts.minute;
        s_second <= ts.second;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        local_times_due.push_back(shift_to_local(ts, zone_hours_q, zone_east_q));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_stamp(random_stamp());
    endtask

    // Stop sending and wait until every result is out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (local_times_due.size() != 0) @(posedge aclk);
    endtask

    // Register write transaction; cfg_valid stays high unless last is set
    task automatic cfg_write(input logic [1:0] idx, input logic [3:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            utz_pkg::CFG_ZONE_HOURS: zone_hours_q = data;
            utz_pkg::CFG_ZONE_EAST:  zone_east_q  = data[0];
            default: ;
        endcase
        if (last) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // Both registers, only with the pipeline empty; upper east bits are junk
    task automatic set_zone(input logic [3:0] hours, input logic east);
        wait_for_drain();
        cfg_write(utz_pkg::CFG_ZONE_HOURS, hours, 1'b0);
        cfg_write(utz_pkg::CFG_ZONE_EAST, {3'($urandom), east}, 1'b1);
    endtask

    // Calendar corners under the reset setting, then far west, then no shift
    task automatic test_directed_corners();
        send_stamp(make_stamp(100, 2, 28, 20, 0, 0));    // 2000 is leap
        send_stamp(make_stamp(0, 2, 28, 20, 1, 1));      // 1900 is not
        send_stamp(make_stamp(200, 2, 28, 21, 2, 2));    // 2100 is not
        send_stamp(make_stamp(104, 2, 29, 23, 3, 3));
        send_stamp(make_stamp(255, 12, 31, 22, 59, 60)); // year wraps up
        send_stamp(make_stamp(99, 4, 30, 16, 4, 4));
        send_stamp(make_stamp(50, 7, 15, 31, 5, 5));     // hour past range
        send_stamp(make_stamp(50, 0, 31, 20, 6, 6));     // month 0
        send_stamp(make_stamp(50, 15, 31, 20, 7, 7));    // month 15
        send_stamp(make_stamp(50, 6, 0, 18, 8, 8));      // day 0 forward
        send_stamp(make_stamp(123, 3, 31, 0, 63, 63));
        send_stamp(make_stamp(1, 1, 10, 15, 0, 0));
        set_zone(4'd12, 1'b0);
        send_stamp(make_stamp(0, 1, 1, 0, 10, 10));      // year wraps down
        send_stamp(make_stamp(100, 3, 1, 5, 11, 11));    // back to Feb 29
        send_stamp(make_stamp(0, 3, 1, 5, 12, 12));      // back to Feb 28
        send_stamp(make_stamp(77, 9, 0, 2, 13, 13));     // day 0 backward
        send_stamp(make_stamp(77, 9, 9, 12, 14, 14));
        send_stamp(make_stamp(77, 13, 1, 3, 15, 15));    // month 13
        send_stamp(make_stamp(77, 5, 1, 11, 16, 16));
        send_stamp(make_stamp(77, 5, 20, 31, 17, 17));
        set_zone(4'd0, 1'b1);
        send_stamp(make_stamp(255, 12, 31, 23, 59, 59));
        send_stamp(make_stamp(0, 0, 0, 31, 63, 63));
        set_zone(4'd15, 1'b0);
        send_stamp(make_stamp(0, 1, 1, 0, 0, 0));
        send_stamp(make_stamp(31, 15, 31, 31, 63, 63));
    endtask

    // Every offset value in both directions
    task automatic test_zone_sweep();
        for (int h = 0; h < 16; h++) begin
            for (int e = 0; e < 2; e++) begin
                set_zone(4'(h), 1'(e));
                send_random(8);
            end
        end
    endtask

    // Writes to unmapped indexes leave the zone setting alone
    task automatic test_spare_cfg_index();
        set_zone(4'd5, 1'b0);
        @(posedge aclk);
        cfg_write(CFG_SPARE_LO, 4'($urandom), 1'b0);
        cfg_write(CFG_SPARE_HI, 4'($urandom), 1'b1);
        send_random(10);
    endtask

    // Output held off long enough to fill the pipeline and stall the input
    task automatic test_output_backpressure();
        set_zone(4'($urandom_range(1, 12)), 1'($urandom));
        sink_hold_request = 60;
        send_random(20);
    endtask

    // Input pauses until the pipeline is empty, then resumes
    task automatic test_drain_pause();
        send_random(20);
        wait_for_drain();
        send_random(20);
    endtask

    // Back to back traffic with no idling on either side
    task automatic test_streaming();
        set_zone(4'($urandom_range(1, 12)), 1'($urandom));
        idle_on = 1'b0;
        send_random(120);
    endtask

    // Result sink: random stalls, plus a long hold on request
    initial begin : result_sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_ready <= 1'b0;
            end else if (sink_hold_request > 0) begin
                sink_stall_left   = sink_hold_request - 1;
                sink_hold_request = 0;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result check against the oldest pending local time
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (local_times_due.size() == 0) begin
                $display("%0t: result transaction with nothing pending", $time);
                mismatch_count++;
            end else begin
                due_stamp = local_times_due.pop_front();
                compare_field("year", 32'(due_stamp.year), 32'(m_out_year));
                compare_field("month", 32'(due_stamp.month), 32'(m_out_month));
                compare_field("day", 32'(due_stamp.day), 32'(m_out_day));
                compare_field("hour", 32'(due_stamp.hour), 32'(m_out_hour));
                compare_field("minute", 32'(due_stamp.minute), 32'(m_out_minute));
                compare_field("second", 32'(due_stamp.second), 32'(m_out_second));
                compare_field("shifted", 32'(due_stamp.shifted), 32'(m_shifted));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utc_time_zone_shift_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        mismatch_count    = 0;
        cycle_count       = 0;
        sink_hold_request = 0;
        sink_stall_left   = 0;
        idle_on           = 1'b1;
        zone_hours_q      = 4'd8;
        zone_east_q       = 1'b1;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= utz_pkg::CFG_ZONE_HOURS;
        cfg_data  <= 4'd0;
        s_valid   <= 1'b0;
        s_year    <= 8'd0;
        s_month   <= 4'd0;
        s_day     <= 5'd0;
        s_hour    <= 5'd0;
        s_minute  <= 6'd0;
        s_second  <= 6'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_zone_sweep();
        test_spare_cfg_index();
        test_output_backpressure();
        test_drain_pause();
        test_streaming();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("utc_time_zone_shift_unit_tb: done, clean");
        end else begin
            $display("utc_time_zone_shift_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
